// ===== rtl/core/sfd_pkg.sv =====
// Shared constants and types for the SLIP frame decoder.
package sfd_pkg;

  // Largest number of bytes kept in one frame.
  localparam int MAX_FRAME = 128;
  // The frame counter is eight bits wide, so the usable limit stops at 255.
  localparam int FRAME_LIMIT_INT = (MAX_FRAME > 255) ? 255 : MAX_FRAME;
  localparam logic [7:0] FRAME_LIMIT = FRAME_LIMIT_INT[7:0];

  // SLIP special bytes.
  localparam logic [7:0] FRAME_END    = 8'hC0;
  localparam logic [7:0] FRAME_ESC    = 8'hDB;
  localparam logic [7:0] ESC_CODE_END = 8'hDC;
  localparam logic [7:0] ESC_CODE_ESC = 8'hDD;

  // Result kinds.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_END_GOOD  = 2'd1;
  localparam logic [1:0] KIND_END_DROP  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] length;
  } sfd_result_t;

endpackage

// ===== rtl/core/sfd_in_stage.sv =====
// Input register stage: holds one received byte until the decoder takes it.
module sfd_in_stage import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // A new beat is taken when the stage is empty or its byte leaves this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

// ===== rtl/core/sfd_decode.sv =====
// SLIP decode logic with the escape flag, frame counter and overflow flag.
module sfd_decode import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        held_valid,
  input  logic [7:0]  held_byte,
  input  logic        out_room,
  output logic        take,
  output logic        res_valid,
  output sfd_result_t res
);

  logic       esc_r;
  logic       esc_nxt;
  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic       ovf_r;
  logic       ovf_nxt;
  logic [7:0] data_byte;
  logic       has_res;

  always_comb begin
    esc_nxt   = esc_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    has_res   = 1'b0;
    res       = '0;
    data_byte = held_byte;
    if (!esc_r && held_byte == FRAME_ESC) begin
      esc_nxt = 1'b1;
    end else if (!esc_r && held_byte == FRAME_END) begin
      // An empty frame is ignored entirely.
      if (count_r != 8'd0) begin
        has_res    = 1'b1;
        res.kind   = ovf_r ? KIND_END_DROP : KIND_END_GOOD;
        res.length = count_r;
        count_nxt  = 8'd0;
        ovf_nxt    = 1'b0;
      end
    end else begin
      if (esc_r) begin
        case (held_byte)
          ESC_CODE_END: data_byte = FRAME_END;
          ESC_CODE_ESC: data_byte = FRAME_ESC;
          default:      data_byte = held_byte;
        endcase
      end
      esc_nxt = 1'b0;
      if (count_r < FRAME_LIMIT) begin
        count_nxt = count_r + 8'd1;
        has_res   = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = data_byte;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // A byte with no result never waits on the output side.
  assign take      = held_valid && (out_room || !has_res);
  assign res_valid = take && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      count_r <= 8'd0;
      ovf_r   <= 1'b0;
    end else if (take) begin
      esc_r   <= esc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/core/sfd_out_stage.sv =====
// Output register stage: holds one result beat until the receiver takes it.
module sfd_out_stage import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  sfd_result_t res,
  output logic        out_room,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_frame_length
);

  logic        valid_r;
  logic        valid_nxt;
  sfd_result_t res_r;

  assign out_room  = !valid_r || out_ready;
  assign valid_nxt = res_valid ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = res_r.kind;
  assign out_byte         = res_r.data;
  assign out_frame_length = res_r.length;

endmodule

// ===== rtl/core/slip_frame_decoder.sv =====
// Top level of the SLIP receive-side frame decoder.
//
// The input channel (in_valid, in_ready, in_byte) carries one raw byte from
// the serial link per beat. The output channel (out_valid, out_ready, out_kind,
// out_byte, out_frame_length) carries at most one result beat per input byte:
// a decoded data byte, or a frame end that reports the kept length and whether
// bytes were dropped because the frame grew past MAX_FRAME.
// ESC bytes and empty frame ends produce no output beat.
// An accepted byte is registered in the input stage, decoded combinationally
// from there, and its result is registered again in the output stage, where
// it is offered to the receiver. The block takes one byte every cycle as long
// as the receiver keeps up; the combinational decode and counter update set
// that rate.
// When the receiver stalls, the output register holds its beat, one more byte
// waits in the input register, and in_ready drops only when both are full.
// Bytes that produce no result keep flowing through the decoder during a stall.
// Synchronous active-low reset empties both registers, clears the escape flag,
// the frame counter and the overflow flag, so decoding starts in a new frame.
module slip_frame_decoder import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [7:0] out_frame_length
);

  logic        take;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        out_room;
  logic        res_valid;
  sfd_result_t res;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Decoder state advances only when the held byte is actually consumed.
  sfd_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .out_room   (out_room),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .out_room         (out_room),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_length (out_frame_length)
  );

endmodule
